>>> hw/rtl/dfs_cc_pkg.sv
// Package with shared types and codes for the connected-components search block.
package dfs_cc_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [1:0] OP_RUN      = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_LINK,
    ST_RUN_ROOT,
    ST_RUN_HEAD,
    ST_RUN_SCAN,
    ST_RUN_ENT,
    ST_RUN_POP,
    ST_RUN_DONE
  } dfs_state_e;

endpackage

>>> hw/rtl/dfs_cc_ram.sv
// Simple dual-port memory with one write port and one registered read port.
module dfs_cc_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/dfs_connected_components_top.sv
// Top level of the connected-components block: sequencer, stack and list memories.
//
// Usage. An item is accepted at a clock edge with start_i high and busy_o low.
// operation_i selects add edge, run traversal or clear graph; first_vertex_i and
// second_vertex_i carry the edge endpoints. busy_o stays high while the item is
// processed. Add edge does two list appends, each a read of the list head/tail
// memory and a link write; clear leaves busy_o low.
// A run emits one result per visited vertex, in depth-first preorder, as a
// one-cycle valid_o strobe with vertex_o, component_index_o,
// first_of_component_o, last_o and edge_overflow_o. Results are held back by one
// so that last_o can be set on the final one; that one comes in the same cycle
// that busy_o falls. A run steps through the roots one at a time, with a head
// fetch, an end-of-list check and a stack pop per visited vertex, and steps the
// single read port of the entry memory once per list entry scanned.
// cfg_we_i writes num_vertices; write it only while busy_o is low.
// Reset empties the graph at once through per-vertex valid bits, clears the
// overflow flag and sets num_vertices to 64. The receiver cannot stall: each
// result transfer happens in the cycle valid_o is high.
module dfs_connected_components_top
  import dfs_cc_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] operation_i,
  input  logic [5:0] first_vertex_i,
  input  logic [5:0] second_vertex_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  output logic       valid_o,
  output logic [5:0] vertex_o,
  output logic [5:0] component_index_o,
  output logic       first_of_component_o,
  output logic       last_o,
  output logic       edge_overflow_o
);

  localparam int EntryCount = 2 * MAX_EDGES;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int EW = $clog2(EntryCount);
  localparam int UW = $clog2(EntryCount + 1);

  dfs_state_e state_q, state_d;
  logic              side_q, side_d;
  logic [VW-1:0]     a_q, a_d, b_q, b_d;
  logic [UW-1:0]     used_q, used_d;
  logic              ovf_q, ovf_d;
  logic [MAX_VERTICES-1:0] ht_valid_q, ht_valid_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [CW-1:0]     root_q, root_d, comp_q, comp_d, depth_q, depth_d;
  logic [EW:0]       cur_q, cur_d;
  logic              pend_vld_q, pend_vld_d, pend_first_q, pend_first_d;
  logic [VW-1:0]     pend_v_q, pend_v_d;
  logic [CW-1:0]     pend_comp_q, pend_comp_d;
  logic              out_valid_q, out_valid_d, out_first_q, out_first_d;
  logic              out_last_q, out_last_d;
  logic [VW-1:0]     out_v_q, out_v_d;
  logic [CW-1:0]     out_comp_q, out_comp_d;
  logic [6:0]        nv_q;
  logic              ht_vld_rd_q;
  logic [CW-1:0]     limit;

  // Memory port controls.
  logic              ht_we, nb_we, nx_we, st_we;
  logic [VW-1:0]     ht_waddr, ht_raddr, st_waddr, st_raddr;
  logic [2*EW-1:0]   ht_wdata, ht_rdata;
  logic [EW-1:0]     nb_waddr, nx_waddr, ent_raddr;
  logic [VW-1:0]     nb_wdata, nb_rdata;
  logic [EW:0]       nx_wdata, nx_rdata, st_wdata, st_rdata;

  // Emission request from the sequencer.
  logic              emit_en, emit_first;
  logic [VW-1:0]     emit_v;
  logic [VW-1:0]     owner, other, found;
  logic              a_ok, b_ok, room;

  dfs_cc_ram #(.Width(2 * EW), .Depth(MAX_VERTICES)) u_head_tail (
    .clk_i, .we_i(ht_we), .waddr_i(ht_waddr), .wdata_i(ht_wdata),
    .raddr_i(ht_raddr), .rdata_o(ht_rdata)
  );
  dfs_cc_ram #(.Width(VW), .Depth(EntryCount)) u_neighbor (
    .clk_i, .we_i(nb_we), .waddr_i(nb_waddr), .wdata_i(nb_wdata),
    .raddr_i(ent_raddr), .rdata_o(nb_rdata)
  );
  dfs_cc_ram #(.Width(EW + 1), .Depth(EntryCount)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(ent_raddr), .rdata_o(nx_rdata)
  );
  dfs_cc_ram #(.Width(EW + 1), .Depth(MAX_VERTICES)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  // Roots tried are saturated to the vertex capacity.
  assign limit = (int'(nv_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(nv_q);
  assign a_ok  = int'(first_vertex_i) < MAX_VERTICES;
  assign b_ok  = int'(second_vertex_i) < MAX_VERTICES;
  assign room  = ({1'b0, used_q} + (UW + 1)'(2)) <= (UW + 1)'(EntryCount);
  assign owner = side_q ? b_q : a_q;
  assign other = side_q ? a_q : b_q;
  assign found = nb_rdata;

  // Next state, memory controls and result staging.
  always_comb begin
    state_d      = state_q;
    side_d       = side_q;
    a_d          = a_q;
    b_d          = b_q;
    used_d       = used_q;
    ovf_d        = ovf_q;
    ht_valid_d   = ht_valid_q;
    visited_d    = visited_q;
    root_d       = root_q;
    comp_d       = comp_q;
    depth_d      = depth_q;
    cur_d        = cur_q;
    pend_vld_d   = pend_vld_q;
    pend_v_d     = pend_v_q;
    pend_comp_d  = pend_comp_q;
    pend_first_d = pend_first_q;
    out_valid_d  = 1'b0;
    out_v_d      = out_v_q;
    out_comp_d   = out_comp_q;
    out_first_d  = out_first_q;
    out_last_d   = out_last_q;
    ht_we        = 1'b0;
    ht_waddr     = owner;
    ht_wdata     = '0;
    ht_raddr     = owner;
    nb_we        = 1'b0;
    nb_waddr     = EW'(used_q);
    nb_wdata     = other;
    nx_we        = 1'b0;
    nx_waddr     = EW'(used_q);
    nx_wdata     = {1'b1, EW'(0)};
    ent_raddr    = cur_q[EW-1:0];
    st_we        = 1'b0;
    st_waddr     = VW'(depth_q - CW'(1));
    st_wdata     = nx_rdata;
    st_raddr     = VW'(depth_q - CW'(2));
    emit_en      = 1'b0;
    emit_first   = 1'b0;
    emit_v       = found;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (operation_i)
            OP_ADD_EDGE: begin
              if (a_ok && b_ok) begin
                if (room) begin
                  a_d     = VW'(first_vertex_i);
                  b_d     = VW'(second_vertex_i);
                  side_d  = 1'b0;
                  state_d = ST_ADD_RD;
                end else begin
                  ovf_d = 1'b1;
                end
              end
            end
            OP_RUN: begin
              visited_d  = '0;
              root_d     = '0;
              comp_d     = '0;
              pend_vld_d = 1'b0;
              state_d    = ST_RUN_ROOT;
            end
            OP_CLEAR: begin
              ht_valid_d = '0;
              used_d     = '0;
              ovf_d      = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // Write the new entry and fetch the owner's head and tail.
      ST_ADD_RD: begin
        nb_we   = 1'b1;
        nx_we   = 1'b1;
        state_d = ST_ADD_LINK;
      end
      // Link the new entry behind the old tail and update head and tail.
      ST_ADD_LINK: begin
        ht_we = 1'b1;
        if (ht_vld_rd_q) begin
          nx_we    = 1'b1;
          nx_waddr = ht_rdata[EW-1:0];
          nx_wdata = {1'b0, EW'(used_q)};
          ht_wdata = {ht_rdata[2*EW-1:EW], EW'(used_q)};
        end else begin
          ht_wdata = {EW'(used_q), EW'(used_q)};
        end
        ht_valid_d[owner] = 1'b1;
        used_d = used_q + UW'(1);
        if (side_q) begin
          state_d = ST_IDLE;
        end else begin
          side_d  = 1'b1;
          state_d = ST_ADD_RD;
        end
      end
      // Try the next root.
      ST_RUN_ROOT: begin
        ht_raddr = VW'(root_q);
        if (root_q == limit) begin
          state_d = ST_RUN_DONE;
        end else if (visited_q[VW'(root_q)]) begin
          root_d = root_q + CW'(1);
        end else begin
          visited_d[VW'(root_q)] = 1'b1;
          emit_en    = 1'b1;
          emit_first = 1'b1;
          emit_v     = VW'(root_q);
          depth_d    = CW'(1);
          state_d    = ST_RUN_HEAD;
        end
      end
      // Start the new level's cursor at its list head.
      ST_RUN_HEAD: begin
        cur_d   = ht_vld_rd_q ? {1'b0, ht_rdata[2*EW-1:EW]} : {1'b1, EW'(0)};
        state_d = ST_RUN_SCAN;
      end
      // Fetch the entry under the cursor, or leave an exhausted level.
      ST_RUN_SCAN: begin
        if (!cur_q[EW]) begin
          state_d = ST_RUN_ENT;
        end else if (depth_q == CW'(1)) begin
          comp_d  = comp_q + CW'(1);
          root_d  = root_q + CW'(1);
          state_d = ST_RUN_ROOT;
        end else begin
          depth_d = depth_q - CW'(1);
          state_d = ST_RUN_POP;
        end
      end
      // Examine one neighbor; descend if it is new.
      ST_RUN_ENT: begin
        ht_raddr = found;
        if (!visited_q[found]) begin
          if (int'(depth_q) < MAX_VERTICES) begin
            visited_d[found] = 1'b1;
            emit_en  = 1'b1;
            st_we    = 1'b1;
            depth_d  = depth_q + CW'(1);
            state_d  = ST_RUN_HEAD;
          end else begin
            cur_d   = {1'b1, EW'(0)};
            state_d = ST_RUN_SCAN;
          end
        end else begin
          cur_d   = nx_rdata;
          state_d = ST_RUN_SCAN;
        end
      end
      // Restore the parent's cursor from the stack.
      ST_RUN_POP: begin
        cur_d   = st_rdata;
        state_d = ST_RUN_SCAN;
      end
      // Release the held result as the last of the run.
      ST_RUN_DONE: begin
        if (pend_vld_q) begin
          out_valid_d = 1'b1;
          out_v_d     = pend_v_q;
          out_comp_d  = pend_comp_q;
          out_first_d = pend_first_q;
          out_last_d  = 1'b1;
          pend_vld_d  = 1'b0;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // A new result pushes the held one out.
    if (emit_en) begin
      if (pend_vld_q) begin
        out_valid_d = 1'b1;
        out_v_d     = pend_v_q;
        out_comp_d  = pend_comp_q;
        out_first_d = pend_first_q;
        out_last_d  = 1'b0;
      end
      pend_vld_d   = 1'b1;
      pend_v_d     = emit_v;
      pend_comp_d  = comp_q;
      pend_first_d = emit_first;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      ovf_q       <= 1'b0;
      ht_valid_q  <= '0;
      visited_q   <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      nv_q        <= 7'd64;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ovf_q       <= ovf_d;
      ht_valid_q  <= ht_valid_d;
      visited_q   <= visited_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        nv_q <= cfg_wdata_i;
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    side_q       <= side_d;
    a_q          <= a_d;
    b_q          <= b_d;
    root_q       <= root_d;
    comp_q       <= comp_d;
    depth_q      <= depth_d;
    cur_q        <= cur_d;
    pend_v_q     <= pend_v_d;
    pend_comp_q  <= pend_comp_d;
    pend_first_q <= pend_first_d;
    out_v_q      <= out_v_d;
    out_comp_q   <= out_comp_d;
    out_first_q  <= out_first_d;
    out_last_q   <= out_last_d;
    ht_vld_rd_q  <= ht_valid_q[ht_raddr];
  end

  assign busy_o               = (state_q != ST_IDLE);
  assign valid_o              = out_valid_q;
  assign vertex_o             = 6'(out_v_q);
  assign component_index_o    = 6'(out_comp_q);
  assign first_of_component_o = out_first_q;
  assign last_o               = out_last_q;
  assign edge_overflow_o      = ovf_q;

  // The last result of a run is never followed at once by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("result strobe right after last result");

  // An accepted run keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && operation_i == OP_RUN |=> busy_o)
    else $error("run item not taken up");

  // The walk never goes deeper than the vertex capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> int'(depth_q) <= MAX_VERTICES || state_q == ST_ADD_RD
      || state_q == ST_ADD_LINK || state_q == ST_RUN_ROOT
      || state_q == ST_RUN_DONE)
    else $error("walk depth beyond capacity");

endmodule
